/* hdl/kbt_pkg.sv */
package kbt_pkg;

    // field widths of one request word and one response word
    localparam int OP_W   = 3;
    localparam int KEY_W  = 31;
    localparam int AMT_W  = 32;
    localparam int ST_W   = 3;
    localparam int SLOT_W = 7;
    localparam int BAL_W  = 48;

    localparam int DEPTH_DEF = 128;

    // operation codes
    localparam logic [OP_W-1:0] OP_DEBIT  = 3'd0;
    localparam logic [OP_W-1:0] OP_CREDIT = 3'd1;
    localparam logic [OP_W-1:0] OP_CREATE = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK           = 3'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND    = 3'd1;
    localparam logic [ST_W-1:0] ST_INSUFFICIENT = 3'd2;
    localparam logic [ST_W-1:0] ST_EXISTS       = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL         = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [BAL_W-1:0] bal;
    } t_entry;

    // saturate a balance result one bit wider into the balance range
    function automatic logic signed [BAL_W-1:0] clamp_bal(input logic signed [BAL_W:0] v);
        logic signed [BAL_W-1:0] res;
        if (v[BAL_W] != v[BAL_W-1]) begin
            res = v[BAL_W] ? {1'b1, {(BAL_W-1){1'b0}}} : {1'b0, {(BAL_W-1){1'b1}}};
        end else begin
            res = v[BAL_W-1:0];
        end
        return res;
    endfunction

endpackage

/* hdl/kbt_if.sv */
interface kbt_in_if;
    import kbt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic [KEY_W-1:0]        key;
    logic signed [AMT_W-1:0] amount;

    modport source (output valid, output op, output key, output amount, input ready);
    modport sink   (input valid, input op, input key, input amount, output ready);
endinterface

interface kbt_out_if;
    import kbt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic [SLOT_W-1:0]       slot;
    logic signed [BAL_W-1:0] old_balance;
    logic signed [BAL_W-1:0] new_balance;

    modport source (output valid, output status, output slot, output old_balance,
                    output new_balance, input ready);
    modport sink   (input valid, input status, input slot, input old_balance,
                    input new_balance, output ready);
endinterface

/* hdl/kbt_mem.sv */
module kbt_mem #(
    parameter int DEPTH = kbt_pkg::DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  kbt_pkg::t_entry  i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output kbt_pkg::t_entry  o_rdata
);
    import kbt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/keyed_balance_table_unit.sv */
// Each item is searched against every live entry in turn and then executed; its response word
// also waits while the previous response word is stalled. A new item is taken only after the
// sequencer is done with the last one, including the compaction that a delete makes of the
// entries above the deleted slot. The search and the compaction both walk the entries through
// the single read port of the entry memory, one entry a cycle.
// Reset (i_rst_n low at a clock edge) empties the table and drops any pending response;
// the entry memory itself is not cleared and needs no clearing pass.
module keyed_balance_table_unit #(
    parameter int TABLE_DEPTH = kbt_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kbt_in_if.sink    i_req,
    kbt_out_if.source o_rsp
);
    import kbt_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SRCH  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_SHIFT = 2'd3;

    logic [1:0]              r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_idx, n_idx;
    logic                    r_rd_vld, n_rd_vld;
    logic [IW-1:0]           r_rd_addr, n_rd_addr;

    // request held for the whole of its processing
    logic [OP_W-1:0]         r_op;
    logic [KEY_W-1:0]        r_key;
    logic signed [AMT_W-1:0] r_amt;

    // search outcome: the last match in slot order is the highest slot
    logic                    r_hit, n_hit;
    logic [IW-1:0]           r_hit_slot, n_hit_slot;
    logic signed [BAL_W-1:0] r_hit_bal, n_hit_bal;

    // response register, parts the sequencer from the sink
    logic                    r_out_vld, n_out_vld;
    logic [ST_W-1:0]         r_out_st;
    logic [SLOT_W-1:0]       r_out_slot;
    logic signed [BAL_W-1:0] r_out_old, r_out_new;

    // memory port
    logic                    w_we;
    logic [IW-1:0]           w_waddr;
    t_entry                  w_wdata;
    t_entry                  w_rdata;
    logic                    w_rd_issue;

    // execute-stage results
    logic [ST_W-1:0]         w_st;
    logic [IW-1:0]           w_slot;
    logic signed [BAL_W-1:0] w_old, w_new;
    logic                    w_upd;
    logic [IW-1:0]           w_upd_addr;
    logic signed [BAL_W-1:0] w_amt_ext;
    logic signed [BAL_W:0]   w_sum, w_diff;
    logic                    w_out_free;
    logic                    w_full;

    kbt_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_idx[IW-1:0]),
        .o_rdata(w_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_out_free  = !r_out_vld || o_rsp.ready;
    assign w_full      = (r_count == CW'(TABLE_DEPTH));

    // walk the live entries, one read a cycle, in both search and compaction
    assign w_rd_issue = ((r_state == S_SRCH) || (r_state == S_SHIFT)) && (r_idx < r_count);

    // one wide add and one wide subtract, each saturated
    assign w_amt_ext = BAL_W'(r_amt);
    assign w_sum     = (BAL_W+1)'(r_hit_bal) + (BAL_W+1)'(w_amt_ext);
    assign w_diff    = (BAL_W+1)'(r_hit_bal) - (BAL_W+1)'(w_amt_ext);

    // decide the response and the write-back of one request
    always_comb begin
        w_st       = ST_OK;
        w_slot     = r_hit_slot;
        w_old      = r_hit_bal;
        w_new      = r_hit_bal;
        w_upd      = 1'b0;
        w_upd_addr = r_hit_slot;
        if (r_op == OP_CREATE) begin
            if (r_hit) begin
                w_st = ST_EXISTS;
            end else if (w_full) begin
                w_st   = ST_FULL;
                w_slot = '0;
                w_old  = '0;
                w_new  = '0;
            end else begin
                // append at the end with a zero balance
                w_slot     = r_count[IW-1:0];
                w_old      = '0;
                w_new      = '0;
                w_upd      = 1'b1;
                w_upd_addr = r_count[IW-1:0];
            end
        end else if (!r_hit) begin
            w_st   = ST_NOT_FOUND;
            w_slot = '0;
            w_old  = '0;
            w_new  = '0;
        end else begin
            case (r_op)
                OP_DEBIT: begin
                    if (w_amt_ext > r_hit_bal) begin
                        w_st = ST_INSUFFICIENT;
                    end else begin
                        w_new = clamp_bal(w_diff);
                        w_upd = 1'b1;
                    end
                end
                OP_CREDIT: begin
                    w_new = clamp_bal(w_sum);
                    w_upd = 1'b1;
                end
                OP_DELETE: begin
                    w_new = '0;
                end
                default: begin
                    // query, and the unused codes act as a query
                    w_new = r_hit_bal;
                end
            endcase
        end
    end

    // memory write: the execute step, or one move of the compaction
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_upd_addr;
        w_wdata = '{key: r_key, bal: w_new};
        if (r_state == S_EXEC) begin
            w_we = w_upd && w_out_free;
        end else if (r_state == S_SHIFT) begin
            // move the entry just read down one place
            w_we    = r_rd_vld;
            w_waddr = IW'(r_rd_addr - IW'(1));
            w_wdata = w_rdata;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_rd_vld   = 1'b0;
        n_rd_addr  = r_rd_addr;
        n_hit      = r_hit;
        n_hit_slot = r_hit_slot;
        n_hit_bal  = r_hit_bal;
        n_out_vld  = r_out_vld && !o_rsp.ready;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_SRCH;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                end
            end
            S_SRCH: begin
                if (w_rd_issue) begin
                    n_rd_vld  = 1'b1;
                    n_rd_addr = r_idx[IW-1:0];
                    n_idx     = r_idx + CW'(1);
                end
                if (r_rd_vld && (w_rdata.key == r_key)) begin
                    n_hit      = 1'b1;
                    n_hit_slot = r_rd_addr;
                    n_hit_bal  = w_rdata.bal;
                end
                // advance once the last read has been compared
                if (!w_rd_issue && !r_rd_vld) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the response register is free
                if (w_out_free) begin
                    n_out_vld = 1'b1;
                    if ((r_op == OP_CREATE) && (w_st == ST_OK)) begin
                        n_count = r_count + CW'(1);
                        n_state = S_IDLE;
                    end else if ((r_op == OP_DELETE) && r_hit) begin
                        n_idx   = CW'(r_hit_slot) + CW'(1);
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SHIFT: begin
                if (w_rd_issue) begin
                    n_rd_vld  = 1'b1;
                    n_rd_addr = r_idx[IW-1:0];
                    n_idx     = r_idx + CW'(1);
                end
                if (!w_rd_issue && !r_rd_vld) begin
                    n_count = r_count - CW'(1);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload and walk registers need no reset
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_rd_addr  <= n_rd_addr;
        r_hit      <= n_hit;
        r_hit_slot <= n_hit_slot;
        r_hit_bal  <= n_hit_bal;
        if (i_req.valid && i_req.ready) begin
            r_op  <= i_req.op;
            r_key <= i_req.key;
            r_amt <= i_req.amount;
        end
        if ((r_state == S_EXEC) && w_out_free) begin
            r_out_st   <= w_st;
            r_out_slot <= SLOT_W'(w_slot);
            r_out_old  <= w_old;
            r_out_new  <= w_new;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.status      = r_out_st;
    assign o_rsp.slot        = r_out_slot;
    assign o_rsp.old_balance = r_out_old;
    assign o_rsp.new_balance = r_out_new;

endmodule

/* hdl/kbt_check.sv */
module kbt_check (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [kbt_pkg::ST_W-1:0]         i_status,
    input logic [kbt_pkg::SLOT_W-1:0]       i_slot,
    input logic signed [kbt_pkg::BAL_W-1:0] i_old,
    input logic signed [kbt_pkg::BAL_W-1:0] i_new
);
    import kbt_pkg::*;

    // a stalled response word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status) && $stable(i_slot)
            && $stable(i_old) && $stable(i_new))
        else $error("stalled response word changed");

    // one item at a time: ready drops after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second word accepted while busy");

    // missing entry or full table reports no slot and zero balances
    a_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_NOT_FOUND || i_status == ST_FULL)
            |-> i_slot == '0 && i_old == '0 && i_new == '0)
        else $error("response without entry carries data");

    // refused operations leave the balance unchanged
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_INSUFFICIENT || i_status == ST_EXISTS)
            |-> i_old == i_new)
        else $error("refused operation changed balance");

    // no status code beyond the defined set
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status <= ST_FULL)
        else $error("undefined status code");

endmodule

bind keyed_balance_table_unit kbt_check u_kbt_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_req.valid),
    .i_in_ready (i_req.ready),
    .i_out_valid(o_rsp.valid),
    .i_out_ready(o_rsp.ready),
    .i_status   (o_rsp.status),
    .i_slot     (o_rsp.slot),
    .i_old      (o_rsp.old_balance),
    .i_new      (o_rsp.new_balance)
);

/* verif/tb_top.sv */
module tb_top;
    import kbt_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic [SLOT_W-1:0]       slot;
        logic signed [BAL_W-1:0] old_bal;
        logic signed [BAL_W-1:0] new_bal;
    } t_balance_result;

    class balance_scoreboard;
        localparam int     SLOTS      = DEPTH_DEF;
        localparam longint BAL_HI     = 64'sh0000_7FFF_FFFF_FFFF;
        localparam longint BAL_LO     = -BAL_HI - 1;
        localparam int     REPORT_CAP = 50;

        logic [KEY_W-1:0] key_tbl [SLOTS];
        longint           bal_tbl [SLOTS];
        int               live_cnt;
        t_balance_result  pending_q [$];
        int               err_cnt;

        function new();
            live_cnt = 0;
            err_cnt  = 0;
        endfunction

        // highest live slot holding the key, -1 if none
        function int find_slot(logic [KEY_W-1:0] key);
            int hit;
            int i;
            hit = -1;
            for (i = 0; i < live_cnt; i++)
                if (key_tbl[i] == key) hit = i;
            return hit;
        endfunction

        function longint limit_balance(longint v);
            if (v > BAL_HI) return BAL_HI;
            if (v < BAL_LO) return BAL_LO;
            return v;
        endfunction

        // update the table for one accepted request and queue its response word
        function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                   logic signed [AMT_W-1:0] amount);
            t_balance_result res;
            int              hit;
            int              i;
            longint          amt;
            longint          bal;
            longint          nxt;
            amt = amount;
            hit = find_slot(key);
            res = '0;
            if (op == OP_CREATE) begin
                if (hit >= 0) begin
                    res.status  = ST_EXISTS;
                    res.slot    = hit[SLOT_W-1:0];
                    res.old_bal = bal_tbl[hit][BAL_W-1:0];
                    res.new_bal = bal_tbl[hit][BAL_W-1:0];
                end else if (live_cnt >= SLOTS) begin
                    res.status = ST_FULL;
                end else begin
                    key_tbl[live_cnt] = key;
                    bal_tbl[live_cnt] = 0;
                    res.status        = ST_OK;
                    res.slot          = live_cnt[SLOT_W-1:0];
                    live_cnt++;
                end
            end else if (hit < 0) begin
                res.status = ST_NOT_FOUND;
            end else begin
                bal         = bal_tbl[hit];
                res.status  = ST_OK;
                res.slot    = hit[SLOT_W-1:0];
                res.old_bal = bal[BAL_W-1:0];
                res.new_bal = bal[BAL_W-1:0];
                case (op)
                    OP_DEBIT: begin
                        if (amt > bal) begin
                            res.status = ST_INSUFFICIENT;
                        end else begin
                            nxt          = limit_balance(bal - amt);
                            bal_tbl[hit] = nxt;
                            res.new_bal  = nxt[BAL_W-1:0];
                        end
                    end
                    OP_CREDIT: begin
                        nxt          = limit_balance(bal + amt);
                        bal_tbl[hit] = nxt;
                        res.new_bal  = nxt[BAL_W-1:0];
                    end
                    OP_DELETE: begin
                        for (i = hit; i + 1 < live_cnt; i++) begin
                            key_tbl[i] = key_tbl[i + 1];
                            bal_tbl[i] = bal_tbl[i + 1];
                        end
                        live_cnt--;
                        res.new_bal = '0;
                    end
                    default: ;
                endcase
            end
            pending_q.push_back(res);
        endfunction

        function void flag(string what, logic signed [BAL_W-1:0] want,
                           logic signed [BAL_W-1:0] got);
            err_cnt++;
            if (err_cnt <= REPORT_CAP)
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
            else if (err_cnt == REPORT_CAP + 1)
                $display("%0t: further mismatches not shown", $time);
        endfunction

        function void check_response(logic [ST_W-1:0] status, logic [SLOT_W-1:0] slot,
                                     logic signed [BAL_W-1:0] old_bal,
                                     logic signed [BAL_W-1:0] new_bal);
            t_balance_result want;
            if (pending_q.size() == 0) begin
                err_cnt++;
                $display("%0t: response word with nothing expected: status %0d slot %0d",
                         $time, status, slot);
                return;
            end
            want = pending_q.pop_front();
            if (want.status !== status)   flag("status", want.status, status);
            if (want.slot !== slot)       flag("slot", want.slot, slot);
            if (want.old_bal !== old_bal) flag("old_balance", want.old_bal, old_bal);
            if (want.new_bal !== new_bal) flag("new_balance", want.new_bal, new_bal);
        endfunction
    endclass

    localparam logic signed [AMT_W-1:0] AMT_LO  = 32'sh8000_0000;
    localparam logic signed [AMT_W-1:0] AMT_HI  = 32'sh7FFF_FFFF;
    localparam logic [KEY_W-1:0]        KEY_MAX = '1;

    logic i_clk;
    logic i_rst_n;

    kbt_in_if  req_if ();
    kbt_out_if rsp_if ();

    keyed_balance_table_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    balance_scoreboard sb;

    // idle odds per cycle, in percent, for the request and response sides
    int src_idle_pct;
    int sink_idle_pct;
    // valid as the sender last drove it; keeps one assignment per step
    bit req_up;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Response side: check every word taken at this edge, then pick the next
    // ready. Values read here are the ones from before the edge.
    always @(posedge i_clk) begin
        if (rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.status, rsp_if.slot,
                              rsp_if.old_balance, rsp_if.new_balance);
        rsp_if.ready <= i_rst_n && ($urandom_range(99) >= sink_idle_pct);
    end

    // Present one request word and hold it until taken. Valid stays high
    // afterwards, so a back-to-back word is sent without lowering and raising it.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic signed [AMT_W-1:0] amount);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        // valid was lowered in this step: let an edge pass before raising it
        if (!req_up && gap == 0) gap = 1;
        if (gap > 0) begin
            if (req_up) req_if.valid <= 1'b0;
            req_up = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.op     <= op;
        req_if.key    <= key;
        req_if.amount <= amount;
        req_up = 1'b1;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(op, key, amount);
    endtask

    // Drop valid and hold off until every outstanding response word is in.
    task automatic wait_for_results();
        if (req_up) req_if.valid <= 1'b0;
        req_up = 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    // Random traffic. Most keys are taken from the live table so that hits,
    // compaction and a full table are reached; the rest are fresh keys.
    task automatic run_phase(input int send_pct, input int recv_pct, input int n_items,
                             input int create_pct, input int delete_pct);
        int               r;
        int               live;
        int               amt;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        src_idle_pct  = send_pct;
        sink_idle_pct = recv_pct;
        repeat (n_items) begin
            live = sb.live_cnt;
            r    = $urandom_range(99);
            if (r < 3)
                op = OP_W'($urandom_range((1 << OP_W) - 1, OP_DELETE + 1));
            else if (r < 3 + create_pct)
                op = OP_CREATE;
            else if (r < 3 + create_pct + delete_pct)
                op = OP_DELETE;
            else begin
                case ($urandom_range(2))
                    0:       op = OP_DEBIT;
                    1:       op = OP_CREDIT;
                    default: op = OP_QUERY;
                endcase
            end
            if (live > 0 && $urandom_range(99) < ((op == OP_CREATE) ? 25 : 85))
                key = sb.key_tbl[$urandom_range(live - 1)];
            else
                key = KEY_W'($urandom);
            case ($urandom_range(4))
                0: amt = $urandom;
                1: amt = $urandom_range(5000);
                2: amt = -$urandom_range(5000);
                3: amt = $urandom_range(1 << 24);
                default: begin
                    case ($urandom_range(4))
                        0:       amt = AMT_LO;
                        1:       amt = AMT_HI;
                        2:       amt = 0;
                        3:       amt = 1;
                        default: amt = -1;
                    endcase
                end
            endcase
            send_request(op, key, amt);
            // now and then stop the sender until the block has caught up
            if ($urandom_range(99) == 0) wait_for_results();
        end
        wait_for_results();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.op     = OP_QUERY;
        req_if.key    = '0;
        req_if.amount = '0;
        rsp_if.ready  = 1'b0;
        req_up        = 1'b0;
        src_idle_pct  = 28;
        sink_idle_pct = 66;
        sb = new();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: every lookup misses
        send_request(OP_QUERY, '0, '0);
        send_request(OP_DEBIT, KEY_MAX, AMT_HI);
        send_request(OP_DELETE, '0, '0);
        send_request(OP_CREDIT, KEY_W'(5), 1);
        send_request(OP_CREATE, '0, AMT_LO);
        wait_for_results();

        // create on a live key, round trips on the top key, unused codes
        send_request(OP_CREATE, KEY_MAX, '0);
        send_request(OP_CREATE, '0, '0);
        send_request(OP_CREDIT, KEY_MAX, AMT_HI);
        send_request(OP_DEBIT, KEY_MAX, AMT_HI);
        send_request(OP_DEBIT, KEY_MAX, 1);
        send_request(OP_CREDIT, KEY_MAX, -1);
        send_request(OP_DEBIT, KEY_MAX, '0);
        for (int u = OP_DELETE + 1; u < (1 << OP_W); u++)
            send_request(OP_W'(u), KEY_MAX, $urandom);

        // delete from the front and from the end, then append again
        send_request(OP_CREATE, 31'h2AAA_AAAA, '0);
        send_request(OP_CREATE, 31'h5555_5555, '0);
        send_request(OP_DELETE, '0, '0);
        send_request(OP_QUERY, 31'h5555_5555, '0);
        send_request(OP_DELETE, 31'h5555_5555, '0);
        send_request(OP_CREATE, '0, '0);
        send_request(OP_DELETE, 31'h2AAA_AAAA, '0);
        wait_for_results();

        // grow, fill to the limit, then drain with deletes
        run_phase(28, 66, 450, 40, 8);
        run_phase(66, 28, 450, 55, 5);
        run_phase(0, 0, 450, 15, 35);

        // allow a full search plus compaction for any stray word
        repeat (2 * DEPTH_DEF + 16) @(posedge i_clk);
        if (sb.err_cnt == 0 && sb.pending_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
hdl/kbt_pkg.sv
hdl/kbt_if.sv
hdl/kbt_mem.sv
hdl/keyed_balance_table_unit.sv
hdl/kbt_check.sv
verif/tb_top.sv
